// ===== sv/fta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types, widths and constants of the fixed-timestep accumulator.
// ----------------------------------------------------------------------------
package fta_pkg;

  localparam int RateW    = 10;   // tick rate register
  localparam int StepsW   = 11;   // catch-up cap register, step count
  localparam int FrameW   = 24;   // frame clamp register, accepted time
  localparam int TickW    = 64;   // tick counter, times in microseconds
  localparam int RemW     = 20;   // scaled remainder, alpha numerator
  localparam int StepW    = 20;   // step length
  localparam int AccW     = 34;   // remainder plus accepted time times rate
  localparam int QuoAW    = 14;   // whole steps available in one frame
  localparam int DivW     = 20;   // divisor width of the shared divider
  localparam int StepCntW = 6;    // divider iteration count
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  localparam logic [RemW-1:0]   OneSecondUs = 20'd1000000;
  localparam logic [RateW-1:0]  RateLimit   = 10'd1000;
  localparam logic [StepsW-1:0] StepsLimit  = 11'd1024;
  localparam logic [FrameW-1:0] FrameLimit  = 24'd10000000;

  localparam logic [RateW-1:0]  RateReset   = 10'd60;
  localparam logic [StepsW-1:0] StepsReset  = 11'd8;
  localparam logic [FrameW-1:0] FrameReset  = 24'd250000;

  localparam logic [CfgIdxW-1:0] CfgTickRate = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxSteps = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxFrame = 2'd2;

  localparam logic CmdAdvance = 1'b0;
  localparam logic CmdReset   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_RATE,
    STATUS_BAD_STEPS,
    STATUS_BAD_FRAME
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_LAUNCH_A,
    S_WAIT_A,
    S_LAUNCH_L,
    S_WAIT_L,
    S_LAUNCH_E,
    S_WAIT_E,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                  cmd;
    logic [TickW-1:0]      frame_time;
    logic [TickW-1:0]      start_tick;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [TickW-1:0]      next_tick;
    logic [StepW-1:0]      step_length;
    logic [StepsW-1:0]     steps_run;
    logic [TickW-1:0]      dropped_time;
    logic [RemW-1:0]       alpha_numerator;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic [DivW-1:0]       rem_init;
    logic [AccW-1:0]       dividend;
    logic [DivW-1:0]       divisor;
    logic [StepCntW-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [AccW-1:0]       quot;
    logic [DivW-1:0]       rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/fta_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fta_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by all
// divisions of the accumulator.
// ----------------------------------------------------------------------------
module fta_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fta_pkg::div_req_t req_i,
  output fta_pkg::div_rsp_t rsp_o
);
  import fta_pkg::*;

  logic                busy_q, done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [DivW-1:0]     r_q, d_q;
  logic [AccW-1:0]     n_q, q_q;

  logic [DivW:0]       trial;
  logic [DivW+1:0]     diff;
  logic                ge;

  // dividend bits enter MSB first behind the partial remainder
  assign trial = {r_q, n_q[AccW-1]};
  assign diff  = {1'b0, trial} - {2'b00, d_q};
  assign ge    = ~diff[DivW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= req_i.rem_init;
      n_q <= req_i.dividend;
      d_q <= req_i.divisor;
      q_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
      n_q <= {n_q[AccW-2:0], 1'b0};
      q_q <= {q_q[AccW-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

endmodule

`default_nettype wire

// ===== sv/fixed_timestep_accumulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_timestep_accumulator_unit
// Fixed-timestep accumulator with catch-up cap: turns frame time into whole
// simulation steps, tracks the tick counter, remainder and dropped time.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   cfg       cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//   in        in_valid_i/stall_o     in_data_i  (fta_pkg::in_t)
//   out       out_valid_o/stall_i    out_data_o (fta_pkg::out_t)
//
// An advance runs a bit-serial multiply by the rate, then the shared
// one-bit-per-cycle divider runs 14 steps for whole steps and 20 for the
// step length. When the cap drops steps a further 34-step division follows.
// A reset command loads the counter and remainder and returns no result;
// a bad configuration goes straight to the result.
// Input stalls while an item is in flight; the output register holds a
// result until it is taken, and the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module fixed_timestep_accumulator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fta_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fta_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fta_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fta_pkg::out_t                 out_data_o
);
  import fta_pkg::*;

  state_e              state_q, state_d;
  logic [RateW-1:0]    rate_q;
  logic [StepsW-1:0]   max_steps_q;
  logic [FrameW-1:0]   max_frame_q;
  logic [RemW-1:0]     rem_q;
  logic [TickW-1:0]    tick_q;

  status_e             cfg_status, status_q;
  logic [AccW-1:0]     prod_q, mcand_q;
  logic [RateW-1:0]    rsh_q;
  logic [3:0]          mul_cnt_q;
  logic [TickW-1:0]    drop_q;
  logic [StepsW-1:0]   count_q;
  logic [QuoAW-1:0]    excess_q;
  logic [RemW-1:0]     rem_new_q;
  logic [StepW-1:0]    step_len_q;

  out_t                out_q, out_d;
  logic                out_valid_q, out_free, out_load;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                accept, advance, clamp;
  logic [FrameW-1:0]   accepted;
  logic [QuoAW-1:0]    avail, steps_ext;
  logic                over;
  logic [TickW:0]      drop_sum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign advance     = accept && (in_data_i.cmd == CmdAdvance);
  assign out_free    = !out_valid_q || !out_stall_i;

  // configuration check in priority order
  always_comb begin
    if (rate_q == '0 || rate_q > RateLimit) begin
      cfg_status = STATUS_BAD_RATE;
    end else if (max_steps_q == '0 || max_steps_q > StepsLimit) begin
      cfg_status = STATUS_BAD_STEPS;
    end else if (max_frame_q == '0 || max_frame_q > FrameLimit) begin
      cfg_status = STATUS_BAD_FRAME;
    end else begin
      cfg_status = STATUS_OK;
    end
  end

  assign clamp    = (|in_data_i.frame_time[TickW-1:FrameW]) ||
                    (in_data_i.frame_time[FrameW-1:0] >= max_frame_q);
  assign accepted = clamp ? max_frame_q : in_data_i.frame_time[FrameW-1:0];

  assign avail     = div_rsp.quot[QuoAW-1:0];
  assign steps_ext = {{(QuoAW-StepsW){1'b0}}, max_steps_q};
  assign over      = avail > steps_ext;

  assign drop_sum  = {1'b0, drop_q} + {{(TickW+1-AccW){1'b0}}, div_rsp.quot};

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and divider launch
  always_comb begin
    state_d  = state_q;
    div_req  = '0;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (advance) begin
          state_d = (cfg_status == STATUS_OK) ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        if (mul_cnt_q == 4'd1) begin
          state_d = S_LAUNCH_A;
        end
      end
      S_LAUNCH_A: begin
        div_req.start    = 1'b1;
        div_req.rem_init = prod_q[AccW-1:QuoAW];
        div_req.dividend = {prod_q[QuoAW-1:0], {(AccW-QuoAW){1'b0}}};
        div_req.divisor  = OneSecondUs;
        div_req.steps    = StepCntW'(QuoAW);
        state_d          = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (div_rsp.done) begin
          state_d = S_LAUNCH_L;
        end
      end
      S_LAUNCH_L: begin
        div_req.start    = 1'b1;
        div_req.dividend = {OneSecondUs, {(AccW-RemW){1'b0}}};
        div_req.divisor  = {{(DivW-RateW){1'b0}}, rate_q};
        div_req.steps    = StepCntW'(RemW);
        state_d          = S_WAIT_L;
      end
      S_WAIT_L: begin
        if (div_rsp.done) begin
          state_d = (excess_q != '0) ? S_LAUNCH_E : S_FIN;
        end
      end
      S_LAUNCH_E: begin
        div_req.start    = 1'b1;
        div_req.dividend = AccW'(excess_q) * AccW'(OneSecondUs);
        div_req.divisor  = {{(DivW-RateW){1'b0}}, rate_q};
        div_req.steps    = StepCntW'(AccW);
        state_d          = S_WAIT_E;
      end
      S_WAIT_E: begin
        if (div_rsp.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // configuration registers and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RateReset;
      max_steps_q <= StepsReset;
      max_frame_q <= FrameReset;
      rem_q       <= '0;
      tick_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgTickRate: rate_q      <= cfg_data_i[RateW-1:0];
          CfgMaxSteps: max_steps_q <= cfg_data_i[StepsW-1:0];
          CfgMaxFrame: max_frame_q <= cfg_data_i[FrameW-1:0];
          default:     ;
        endcase
      end
      if (accept && in_data_i.cmd == CmdReset) begin
        rem_q  <= '0;
        tick_q <= in_data_i.start_tick;
      end else if (out_load && status_q == STATUS_OK) begin
        rem_q  <= rem_new_q;
        tick_q <= tick_q + TickW'(count_q);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (advance) begin
          status_q  <= cfg_status;
          prod_q    <= AccW'(rem_q);
          mcand_q   <= AccW'(accepted);
          rsh_q     <= rate_q;
          mul_cnt_q <= 4'(RateW);
          drop_q    <= in_data_i.frame_time - TickW'(accepted);
        end
      end
      S_MUL: begin
        // shift-add, one rate bit per cycle
        if (rsh_q[0]) begin
          prod_q <= prod_q + mcand_q;
        end
        mcand_q   <= {mcand_q[AccW-2:0], 1'b0};
        rsh_q     <= {1'b0, rsh_q[RateW-1:1]};
        mul_cnt_q <= mul_cnt_q - 1'b1;
      end
      S_WAIT_A: begin
        if (div_rsp.done) begin
          count_q   <= over ? max_steps_q : avail[StepsW-1:0];
          excess_q  <= over ? (avail - steps_ext) : '0;
          rem_new_q <= div_rsp.rem[RemW-1:0];
        end
      end
      S_WAIT_L: begin
        if (div_rsp.done) begin
          step_len_q <= div_rsp.quot[StepW-1:0];
        end
      end
      S_WAIT_E: begin
        // saturate the dropped time
        if (div_rsp.done) begin
          drop_q <= drop_sum[TickW] ? {TickW{1'b1}} : drop_sum[TickW-1:0];
        end
      end
      default: ;
    endcase
  end

  fta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    out_d        = '0;
    out_d.status = status_q;
    if (status_q == STATUS_OK) begin
      out_d.next_tick       = tick_q + TickW'(1);
      out_d.step_length     = step_len_q;
      out_d.steps_run       = count_q;
      out_d.dropped_time    = drop_q;
      out_d.alpha_numerator = rem_new_q;
    end
  end

  // output register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && status_q == STATUS_OK) |-> (rem_new_q < OneSecondUs))
    else $error("remainder left after whole steps is out of range");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_WAIT_A || state_q == S_WAIT_L ||
                      state_q == S_WAIT_E))
    else $error("divider finished outside a wait state");

  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STATUS_OK) |->
      (out_data_o.steps_run <= max_steps_q))
    else $error("step count exceeds catch-up cap");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (state_q != S_IDLE || $stable(out_data_o)))
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

// ===== sim/fta_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_frame_checker
// Watches the register, frame and result channels of the accumulator. Keeps
// its own copy of the settings, remainder and tick counter, and predicts each
// frame result. Every result transfer is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module fta_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fta_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fta_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  fta_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  fta_pkg::out_t                 out_data_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o
);
  import fta_pkg::*;

  localparam logic [TickW-1:0] UsPerSecond = OneSecondUs;

  logic [RateW-1:0]  rate_q;
  logic [StepsW-1:0] steps_q;
  logic [FrameW-1:0] frame_q;
  logic [RemW-1:0]   rem_q;
  logic [TickW-1:0]  tick_q;

  out_t        frame_results_q[$];
  int unsigned fails   = 0;
  int unsigned checked = 0;

  // Registers are checked in order: rate, catch-up cap, frame clamp.
  function automatic status_e settings_status();
    if (rate_q == '0 || rate_q > RateLimit) return STATUS_BAD_RATE;
    if (steps_q == '0 || steps_q > StepsLimit) return STATUS_BAD_STEPS;
    if (frame_q == '0 || frame_q > FrameLimit) return STATUS_BAD_FRAME;
    return STATUS_OK;
  endfunction

  task automatic predict_frame(input in_t item);
    logic [TickW-1:0] accepted;
    logic [TickW-1:0] dropped;
    logic [TickW-1:0] acc;
    logic [TickW-1:0] avail;
    logic [TickW-1:0] count;
    logic [TickW-1:0] excess;
    logic [TickW-1:0] lost;
    logic [TickW-1:0] total;
    out_t             want;
    status_e          st;
    if (item.cmd == CmdReset) begin
      rem_q  = '0;
      tick_q = item.start_tick;
      return;
    end
    want = '0;
    st   = settings_status();
    if (st != STATUS_OK) begin
      want.status = st;
      frame_results_q.push_back(want);
      return;
    end
    accepted = frame_q;
    if (item.frame_time < accepted) accepted = item.frame_time;
    dropped = item.frame_time - accepted;
    acc     = rem_q + accepted * rate_q;
    avail   = acc / UsPerSecond;
    count   = steps_q;
    if (avail < count) count = avail;
    acc = acc - count * UsPerSecond;
    want.status      = STATUS_OK;
    want.next_tick   = tick_q + 1;
    want.step_length = UsPerSecond / rate_q;
    tick_q = tick_q + count;
    // Whole steps past the cap leave the remainder and count as dropped time.
    if (avail > steps_q) begin
      excess  = avail - steps_q;
      acc     = acc - excess * UsPerSecond;
      lost    = (excess * UsPerSecond) / rate_q;
      total   = dropped + lost;
      dropped = (total < dropped) ? '1 : total;
    end
    rem_q = acc[RemW-1:0];
    want.steps_run       = count[StepsW-1:0];
    want.dropped_time    = dropped;
    want.alpha_numerator = rem_q;
    frame_results_q.push_back(want);
  endtask

  function automatic bit field_differs(string name, logic [TickW-1:0] want,
                                       logic [TickW-1:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1'b1;
  endfunction

  task automatic compare_result(input out_t got);
    out_t want;
    bit   bad;
    if (frame_results_q.size() == 0) begin
      $display("%0t: result with nothing expected, actual status %0d next_tick %0d",
               $time, got.status, got.next_tick);
      fails++;
      return;
    end
    want = frame_results_q.pop_front();
    bad  = 1'b0;
    bad |= field_differs("status", want.status, got.status);
    bad |= field_differs("next_tick", want.next_tick, got.next_tick);
    bad |= field_differs("step_length", want.step_length, got.step_length);
    bad |= field_differs("steps_run", want.steps_run, got.steps_run);
    bad |= field_differs("dropped_time", want.dropped_time, got.dropped_time);
    bad |= field_differs("alpha_numerator", want.alpha_numerator, got.alpha_numerator);
    if (bad) fails++;
    checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  = RateReset;
      steps_q = StepsReset;
      frame_q = FrameReset;
      rem_q   = '0;
      tick_q  = '0;
      frame_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTickRate: rate_q  = cfg_data_i[RateW-1:0];
          CfgMaxSteps: steps_q = cfg_data_i[StepsW-1:0];
          CfgMaxFrame: frame_q = cfg_data_i[FrameW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_frame(in_data_i);
    end
    // Publish after the edge so the stimulus side never races these counts.
    pending_o  <= frame_results_q.size();
    fail_cnt_o <= fails;
    checked_o  <= checked;
  end

endmodule

// ===== sim/tb_fixed_timestep_accumulator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_timestep_accumulator_unit
// Regression for the fixed-timestep accumulator: directed frames at the edges
// of every register and field, then random phases of settings and frames with
// random idling on both channels, a long result hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_fixed_timestep_accumulator_unit;
  import fta_pkg::*;

  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 120;
  localparam int RandomItems = 1800;
  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;

  logic                clk   = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;

  logic        quiet = 1'b0;
  logic [3:0]  hold_req  = '0;
  logic [3:0]  hold_seen = '0;
  int unsigned hold_left = 0;

  int unsigned cur_rate, cur_steps, cur_frame;
  int unsigned n_adv = 0, n_load = 0, n_settings = 0, n_random = 0;

  fixed_timestep_accumulator_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  fta_frame_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99, 0) < 24);
    end
  end

  task automatic send_frame(input logic cmd, input logic [TickW-1:0] ft,
                            input logic [TickW-1:0] st);
    int   gap;
    in_t  item;
    gap = 0;
    if (!quiet && $urandom_range(99, 0) < 24) gap = $urandom_range(100, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.cmd        = cmd;
    item.frame_time = ft;
    item.start_tick = st;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (cmd == CmdReset) n_load++;
    else n_adv++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait out every pending result plus the block's own latency.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] with_junk(input int unsigned v,
                                                    input logic [CfgDataW-1:0] mask);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    if ($urandom_range(1, 0) == 0) return CfgDataW'(v);
    return CfgDataW'(v) | (junk & ~mask);
  endfunction

  task automatic set_config(input int unsigned r, input int unsigned s, input int unsigned f);
    write_reg(CfgTickRate, with_junk(r, 24'h0003FF));
    write_reg(CfgMaxSteps, with_junk(s, 24'h0007FF));
    write_reg(CfgMaxFrame, CfgDataW'(f));
    cur_rate  = r;
    cur_steps = s;
    cur_frame = f;
    n_settings++;
  endtask

  task automatic pick_config(output bit bad);
    int unsigned r, s, f, roll;
    roll = $urandom_range(99, 0);
    if (roll < 10) r = 1;
    else if (roll < 20) r = 1000;
    else if (roll < 30) r = $urandom_range(10, 1);
    else if (roll < 35) r = $urandom_range(1, 0) ? 0 : $urandom_range(1023, 1001);
    else r = $urandom_range(1000, 1);
    roll = $urandom_range(99, 0);
    if (roll < 15) s = 1;
    else if (roll < 25) s = 1024;
    else if (roll < 50) s = $urandom_range(8, 1);
    else if (roll < 54) s = $urandom_range(1, 0) ? 0 : $urandom_range(2047, 1025);
    else s = $urandom_range(1024, 1);
    roll = $urandom_range(99, 0);
    if (roll < 10) f = 1;
    else if (roll < 20) f = 10000000;
    else if (roll < 30) f = $urandom_range(100, 1);
    else if (roll < 34) f = $urandom_range(1, 0) ? 0 : $urandom_range(16777215, 10000001);
    else f = $urandom_range(10000000, 1);
    set_config(r, s, f);
    bad = (r == 0 || r > 1000 || s == 0 || s > 1024 || f == 0 || f > 10000000);
  endtask

  function automatic logic [TickW-1:0] pick_frame_time();
    int unsigned      roll, k;
    logic [TickW-1:0] ft;
    roll = $urandom_range(99, 0);
    if (roll < 40) ft = TickW'($urandom_range(cur_frame, 0));
    else if (roll < 60) ft = TickW'(cur_frame + $urandom_range(2 * cur_frame, 0));
    else if (roll < 70) ft = TickW'($urandom_range(100, 0));
    else if (roll < 80) ft = {$urandom, $urandom};
    else if (roll < 85) ft = 64'hFFFF_FFFF_FFFF_FFFF - TickW'($urandom_range(1000, 0));
    else if (cur_rate != 0) begin
      // land near a whole number of steps, around the catch-up cap
      k  = $urandom_range(cur_steps + 3, 0);
      ft = TickW'((k * 1000000) / cur_rate + $urandom_range(1, 0));
    end else ft = TickW'($urandom);
    return ft;
  endfunction

  function automatic logic [TickW-1:0] pick_start_tick();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 50) return {$urandom, $urandom};
    if (roll < 75) return 64'hFFFF_FFFF_FFFF_FFFF - TickW'($urandom_range(20, 0));
    return TickW'($urandom_range(1000, 0));
  endfunction

  initial begin
    bit          bad;
    int unsigned phase, len, i;
    logic [TickW-1:0] ones;
    ones = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settings out of reset: small frames, clamp with cap, counter wrap.
    cur_rate = 60; cur_steps = 8; cur_frame = 250000;
    send_frame(CmdAdvance, 0, pick_start_tick());
    send_frame(CmdAdvance, 16667, pick_start_tick());
    send_frame(CmdAdvance, 1, pick_start_tick());
    send_frame(CmdAdvance, ones, pick_start_tick());
    send_frame(CmdReset, pick_frame_time(), ones);
    send_frame(CmdAdvance, 0, 0);
    send_frame(CmdAdvance, 250000, ones);
    wait_idle();

    // Largest valid settings.
    set_config(1000, 1024, 10000000);
    send_frame(CmdAdvance, 10000000, 0);
    send_frame(CmdAdvance, ones, 0);
    send_frame(CmdAdvance, 999, 0);
    send_frame(CmdReset, 0, 0);
    send_frame(CmdAdvance, 1000, ones);
    wait_idle();

    // Smallest valid settings.
    set_config(1, 1, 1);
    send_frame(CmdAdvance, 1, 0);
    send_frame(CmdAdvance, 2, 0);
    send_frame(CmdAdvance, 0, 0);
    send_frame(CmdAdvance, ones, 0);
    wait_idle();

    // Bad settings, including precedence of the rate check.
    set_config(0, 8, 250000);
    send_frame(CmdAdvance, 5000, 0);
    send_frame(CmdReset, 0, 64'd77);
    wait_idle();
    set_config(1023, 0, 0);
    send_frame(CmdAdvance, 5000, 0);
    wait_idle();
    set_config(1001, 8, 250000);
    send_frame(CmdAdvance, 5000, 0);
    wait_idle();
    set_config(5, 0, 250000);
    send_frame(CmdAdvance, 5000, 0);
    wait_idle();
    set_config(5, 2047, 0);
    send_frame(CmdAdvance, 5000, 0);
    wait_idle();
    set_config(5, 4, 0);
    send_frame(CmdAdvance, 5000, 0);
    wait_idle();
    set_config(5, 4, 16777215);
    send_frame(CmdAdvance, 5000, 0);
    wait_idle();
    set_config(5, 4, 10000001);
    send_frame(CmdAdvance, 5000, 0);
    wait_idle();
    // An unmapped index must leave the settings alone.
    set_config(7, 3, 5000);
    write_reg(CfgUnmapped, CfgDataW'($urandom));
    send_frame(CmdAdvance, 3000000, 0);
    send_frame(CmdAdvance, 4999, 0);
    wait_idle();

    phase = 0;
    while (n_random < RandomItems) begin
      wait_idle();
      pick_config(bad);
      len = bad ? 10 : $urandom_range(70, 20);
      if (phase == 2) len = 70;
      quiet <= (phase % 8 == 2);
      // fill the block against a held-off result port
      if (phase == 3) hold_req <= hold_req + 4'd1;
      for (i = 0; i < len; i++) begin
        if (phase == 5 && i == len / 2) wait_idle();
        if ($urandom_range(99, 0) < 8)
          send_frame(CmdReset, pick_frame_time(), pick_start_tick());
        else
          send_frame(CmdAdvance, pick_frame_time(), pick_start_tick());
        n_random++;
      end
      phase++;
    end
    wait_idle();

    $display("covered %0d frame advances and %0d counter loads over %0d register settings",
             n_adv, n_load, n_settings);
    $display("%0d results checked, bad settings, step cap, clamps and long hold-off included",
             checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("fixed_timestep_accumulator_unit regression: pass");
    end else begin
      $display("fixed_timestep_accumulator_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("fixed_timestep_accumulator_unit regression: fail");
    $finish;
  end

endmodule
